// ----- rtl/vgt_pkg.sv -----
package vgt_pkg;

  localparam int unsigned MaxCells     = 1023;
  localparam int unsigned LabelBits    = 16;
  localparam int unsigned CellW        = 10;
  localparam int unsigned LabelW       = 16;
  localparam int unsigned IdxW         = 30;
  localparam int unsigned StrideYW     = 11;
  localparam int unsigned StrideZW     = 21;
  localparam int unsigned TetsPerVoxel = 5;
  localparam int unsigned FifoDepth    = 4;

  localparam logic [LabelW-1:0] LabelMask =
    (LabelBits >= LabelW) ? {LabelW{1'b1}} : LabelW'((64'd1 << LabelBits) - 64'd1);

  localparam logic [2:0] LastTet = 3'(TetsPerVoxel - 1);

  typedef enum logic [1:0] {
    CfgCellsX = 2'd0,
    CfgCellsY = 2'd1,
    CfgCellsZ = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [CellW-1:0] x;
    logic [CellW-1:0] y;
    logic [CellW-1:0] z;
  } cells_t;

  // One voxel as handed from the front to the back
  typedef struct packed {
    logic [IdxW-1:0]     base;
    logic [StrideYW-1:0] sy;
    logic [StrideZW-1:0] sz;
    logic [LabelW-1:0]   label;
    logic                odd;
    logic                last;
  } voxel_t;

  // One tetrahedron result
  typedef struct packed {
    logic [IdxW-1:0]   corner_a;
    logic [IdxW-1:0]   corner_b;
    logic [IdxW-1:0]   corner_c;
    logic [IdxW-1:0]   corner_d;
    logic [LabelW-1:0] label;
    logic              voxel_done;
    logic              grid_done;
  } tet_t;

  // Zero acts as one, values above the limit clamp to it
  function automatic logic [CellW-1:0] eff_cells(input logic [CellW-1:0] r);
    logic [CellW-1:0] v;
    v = r;
    if (v == '0) v = CellW'(1);
    if (32'(v) > MaxCells) v = CellW'(MaxCells);
    return v;
  endfunction

  // Corner codes of one tetrahedron, a in [11:9] down to d in [2:0].
  // Code bit 0 is +x, bit 1 is +y, bit 2 is +z.
  function automatic logic [11:0] split_codes(input logic odd, input logic [2:0] tet);
    logic [11:0] c;
    case ({odd, tet})
      4'b0_000: c = {3'd0, 3'd4, 3'd5, 3'd6};
      4'b0_001: c = {3'd0, 3'd6, 3'd3, 3'd2};
      4'b0_010: c = {3'd0, 3'd1, 3'd3, 3'd5};
      4'b0_011: c = {3'd7, 3'd5, 3'd6, 3'd3};
      4'b0_100: c = {3'd0, 3'd3, 3'd6, 3'd5};
      4'b1_000: c = {3'd0, 3'd4, 3'd1, 3'd2};
      4'b1_001: c = {3'd2, 3'd3, 3'd7, 3'd1};
      4'b1_010: c = {3'd6, 3'd2, 3'd7, 3'd4};
      4'b1_011: c = {3'd5, 3'd1, 3'd4, 3'd7};
      4'b1_100: c = {3'd4, 3'd1, 3'd2, 3'd7};
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/vgt_front.sv -----
module vgt_front #(
  parameter int unsigned Depth = vgt_pkg::FifoDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vgt_pkg::cells_t                cells_i,
  input  logic                           push_i,
  input  logic [vgt_pkg::LabelW-1:0]     label_i,
  output logic                           full_o,
  input  logic [$clog2(Depth+1)-1:0]     level_i,
  output logic                           q_push_o,
  output vgt_pkg::voxel_t                q_data_o
);

  localparam int unsigned CW = vgt_pkg::CellW;

  logic [CW-1:0] cx, cy, cz;
  logic [CW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic          last_x, last_y, last_z;
  logic          accept;
  logic [vgt_pkg::StrideYW-1:0] sy;
  logic [vgt_pkg::StrideZW-1:0] sz_full;
  logic [20:0]                  ysy;

  // Stage A
  logic                         a_v_q;
  logic [CW-1:0]                a_x_q, a_z_q;
  logic [20:0]                  a_ysy_q;
  logic [vgt_pkg::StrideYW-1:0] a_sy_q;
  logic [vgt_pkg::StrideZW-1:0] a_sz_q;
  logic [vgt_pkg::LabelW-1:0]   a_label_q;
  logic                         a_odd_q, a_last_q;

  // Stage B
  logic                         b_v_q;
  logic [21:0]                  b_xy_q;
  logic [vgt_pkg::IdxW-1:0]     b_zsz_q;
  logic [vgt_pkg::StrideYW-1:0] b_sy_q;
  logic [vgt_pkg::StrideZW-1:0] b_sz_q;
  logic [vgt_pkg::LabelW-1:0]   b_label_q;
  logic                         b_odd_q, b_last_q;

  assign cx = vgt_pkg::eff_cells(cells_i.x);
  assign cy = vgt_pkg::eff_cells(cells_i.y);
  assign cz = vgt_pkg::eff_cells(cells_i.z);

  // Reserve a queue slot for every voxel still in the pipeline
  assign full_o = (32'(level_i) + 32'(a_v_q) + 32'(b_v_q)) >= Depth;
  assign accept = push_i && !full_o;

  assign last_x = ({1'b0, pos_x_q} + 11'd1) >= {1'b0, cx};
  assign last_y = ({1'b0, pos_y_q} + 11'd1) >= {1'b0, cy};
  assign last_z = ({1'b0, pos_z_q} + 11'd1) >= {1'b0, cz};

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (accept) begin
      if (!last_x) begin
        pos_x_d = pos_x_q + CW'(1);
      end else begin
        pos_x_d = '0;
        if (!last_y) begin
          pos_y_d = pos_y_q + CW'(1);
        end else begin
          pos_y_d = '0;
          pos_z_d = last_z ? '0 : pos_z_q + CW'(1);
        end
      end
    end
  end

  assign sy      = {1'b0, cx} + 11'd1;
  assign sz_full = 21'(sy) * 21'({1'b0, cy} + 11'd1);
  assign ysy     = 21'(pos_y_q) * 21'(sy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      a_v_q   <= accept;
      b_v_q   <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q     <= pos_x_q;
      a_z_q     <= pos_z_q;
      a_ysy_q   <= ysy;
      a_sy_q    <= sy;
      a_sz_q    <= sz_full;
      a_label_q <= label_i & vgt_pkg::LabelMask;
      a_odd_q   <= pos_x_q[0] ^ pos_y_q[0] ^ pos_z_q[0];
      a_last_q  <= last_x && last_y && last_z;
    end
    if (a_v_q) begin
      b_xy_q    <= 22'(a_x_q) + 22'(a_ysy_q);
      b_zsz_q   <= vgt_pkg::IdxW'(a_z_q) * vgt_pkg::IdxW'(a_sz_q);
      b_sy_q    <= a_sy_q;
      b_sz_q    <= a_sz_q;
      b_label_q <= a_label_q;
      b_odd_q   <= a_odd_q;
      b_last_q  <= a_last_q;
    end
  end

  assign q_push_o       = b_v_q;
  assign q_data_o.base  = vgt_pkg::IdxW'(b_xy_q) + b_zsz_q;
  assign q_data_o.sy    = b_sy_q;
  assign q_data_o.sz    = b_sz_q;
  assign q_data_o.label = b_label_q;
  assign q_data_o.odd   = b_odd_q;
  assign q_data_o.last  = b_last_q;

endmodule

// ----- rtl/vgt_fifo.sv -----
module vgt_fifo #(
  parameter int unsigned Depth = vgt_pkg::FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  vgt_pkg::voxel_t            push_data_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output vgt_pkg::voxel_t            head_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  vgt_pkg::voxel_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0] level_q;
  logic            do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign empty_o = (level_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      level_q <= level_q + LvlW'(push_i) - LvlW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/vgt_back.sv -----
module vgt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  vgt_pkg::voxel_t q_head_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vgt_pkg::tet_t   tet_o
);

  localparam int unsigned IW = vgt_pkg::IdxW;

  vgt_pkg::voxel_t cur_q;
  logic            cur_v_q, cur_v_d;
  logic [2:0]      tet_q, tet_d;
  logic            out_v_q, out_v_d;
  logic            out_load, emit, load_cur;
  logic [11:0]     codes;
  vgt_pkg::tet_t   res_q, res_d;

  function automatic logic [IW-1:0] corner(input vgt_pkg::voxel_t e, input logic [2:0] code);
    logic [IW-1:0] v;
    v = e.base + IW'(code[0]);
    if (code[1]) v = v + IW'(e.sy);
    if (code[2]) v = v + IW'(e.sz);
    return v;
  endfunction

  assign out_load = !out_v_q || pop_i;
  assign emit     = out_load && cur_v_q;
  // Fetch the next voxel when none is held or while the current one issues its last tetrahedron
  assign load_cur = out_load && !q_empty_i && (!cur_v_q || tet_q == vgt_pkg::LastTet);
  assign q_pop_o  = load_cur;

  assign codes = vgt_pkg::split_codes(cur_q.odd, tet_q);

  always_comb begin
    res_d.corner_a   = corner(cur_q, codes[11:9]);
    res_d.corner_b   = corner(cur_q, codes[8:6]);
    res_d.corner_c   = corner(cur_q, codes[5:3]);
    res_d.corner_d   = corner(cur_q, codes[2:0]);
    res_d.label      = cur_q.label;
    res_d.voxel_done = (tet_q == vgt_pkg::LastTet);
    res_d.grid_done  = (tet_q == vgt_pkg::LastTet) && cur_q.last;
  end

  always_comb begin
    out_v_d = out_load ? cur_v_q : out_v_q;
    cur_v_d = cur_v_q;
    tet_d   = tet_q;
    if (emit) begin
      tet_d = (tet_q == vgt_pkg::LastTet) ? 3'd0 : tet_q + 3'd1;
      if (tet_q == vgt_pkg::LastTet) cur_v_d = load_cur;
    end else if (load_cur) begin
      cur_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      tet_q   <= 3'd0;
      out_v_q <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      tet_q   <= tet_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cur) cur_q <= q_head_i;
    if (emit) res_q <= res_d;
  end

  assign empty_o = !out_v_q;
  assign tet_o   = res_q;

endmodule

// ----- rtl/voxel_grid_tetrahedralizer.sv -----
// Channel   Direction  Handshake                 Payload
// input     in         push / full               voxel_label_i
// result    out        empty / pop               corner_a_o..corner_d_o, tet_label_o,
//                                                voxel_done_o, grid_done_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each voxel yields five tetrahedra, one per cycle from the back end while results are
// popped and voxels wait in the queue; the single result port limits the voxel rate.
// After its input transfer the first tetrahedron passes front stages A and B, the queue,
// the current-voxel register and the output register. Reset clears the position, the
// queue and the output and sets the cell counts to one. A stalled result port fills the
// queue; full rises once queue and front stages hold FIFO_DEPTH voxels.
module voxel_grid_tetrahedralizer #(
  parameter int unsigned FIFO_DEPTH = vgt_pkg::FifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input queue side
  input  logic                          push,
  output logic                          full,
  input  logic [vgt_pkg::LabelW-1:0]    voxel_label_i,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output logic [vgt_pkg::IdxW-1:0]      corner_a_o,
  output logic [vgt_pkg::IdxW-1:0]      corner_b_o,
  output logic [vgt_pkg::IdxW-1:0]      corner_c_o,
  output logic [vgt_pkg::IdxW-1:0]      corner_d_o,
  output logic [vgt_pkg::LabelW-1:0]    tet_label_o,
  output logic                          voxel_done_o,
  output logic                          grid_done_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [vgt_pkg::CellW-1:0]     cfg_data_i
);

  vgt_pkg::cells_t                    cells_q;
  logic                               q_push, q_pop, q_empty;
  vgt_pkg::voxel_t                    q_data, q_head;
  logic [$clog2(FIFO_DEPTH+1)-1:0]    q_level;
  vgt_pkg::tet_t                      tet;

  // The user keeps the block idle whenever config writes come; nothing here checks it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q.x <= vgt_pkg::CellW'(1);
      cells_q.y <= vgt_pkg::CellW'(1);
      cells_q.z <= vgt_pkg::CellW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vgt_pkg::CfgCellsX: cells_q.x <= cfg_data_i;
        vgt_pkg::CfgCellsY: cells_q.y <= cfg_data_i;
        vgt_pkg::CfgCellsZ: cells_q.z <= cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Front: walk the raster position and compute the voxel's base vertex
  vgt_front #(
    .Depth (FIFO_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cells_i  (cells_q),
    .push_i   (push),
    .label_i  (voxel_label_i),
    .full_o   (full),
    .level_i  (q_level),
    .q_push_o (q_push),
    .q_data_o (q_data)
  );

  // Queue decoupling the front from the tetrahedron issue
  vgt_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head),
    .level_o     (q_level)
  );

  // Back: issue five tetrahedra per voxel into the output register
  vgt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .tet_o     (tet)
  );

  assign corner_a_o   = tet.corner_a;
  assign corner_b_o   = tet.corner_b;
  assign corner_c_o   = tet.corner_c;
  assign corner_d_o   = tet.corner_d;
  assign tet_label_o  = tet.label;
  assign voxel_done_o = tet.voxel_done;
  assign grid_done_o  = tet.grid_done;

`ifndef ASSERT_OFF
  // The credit check on full must keep the queue from overflowing
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_level) <= FIFO_DEPTH)
    else $error("voxel queue overflow");

  // The grid end flag only comes with the last tetrahedron of a voxel
  a_grid_in_voxel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && grid_done_o) |-> voxel_done_o)
    else $error("grid_done without voxel_done");

  // Tetrahedra of one voxel carry one label
  a_label_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !voxel_done_o) |=> (empty || tet_label_o == $past(tet_label_o)))
    else $error("label changed inside a voxel");
`endif

endmodule
